### rtl/cre_pkg.sv
// Package for the character range expander: payload types, queue command, character codes.
`timescale 1ns / 1ps
package cre_pkg;

  // Character codes
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;

  // Configuration port
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam logic [0:0]  CfgWrapIdx  = 1'b0;
  localparam logic        WrapEnReset = 1'b1;

  // Command queue between front and back
  localparam int unsigned CmdFifoDepth = 2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // Up to two inclusive character runs, emitted in order.
  typedef struct packed {
    logic       seg1_en;
    logic [7:0] seg1_lo;
    logic [7:0] seg1_hi;
    logic       seg2_en;
    logic [7:0] seg2_lo;
    logic [7:0] seg2_hi;
    logic       last;
  } cmd_t;

endpackage

### rtl/cre_front.sv
// Front end: takes characters, tracks the pending dash and turns each item into a run command.
`timescale 1ns / 1ps
module cre_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cre_pkg::in_item_t item_i,
  input  logic              wrap_en_i,
  output logic              cmd_push_o,
  output cre_pkg::cmd_t     cmd_o
);

  logic [7:0] prev_char_q, prev_char_d;
  logic       prev_valid_q, prev_valid_d;
  logic       dash_held_q, dash_held_d;

  logic [7:0] c;
  logic [7:0] lo;
  logic       lo_dig, lo_low, lo_up, c_dig, c_low, c_up, same;
  cre_pkg::cmd_t cmd;

  assign c      = item_i.in_char;
  assign lo     = prev_char_q;
  assign lo_dig = (lo >= cre_pkg::ChZero) && (lo <= cre_pkg::ChNine);
  assign lo_low = (lo >= cre_pkg::ChLowA) && (lo <= cre_pkg::ChLowZ);
  assign lo_up  = (lo >= cre_pkg::ChUpA)  && (lo <= cre_pkg::ChUpZ);
  assign c_dig  = (c >= cre_pkg::ChZero)  && (c <= cre_pkg::ChNine);
  assign c_low  = (c >= cre_pkg::ChLowA)  && (c <= cre_pkg::ChLowZ);
  assign c_up   = (c >= cre_pkg::ChUpA)   && (c <= cre_pkg::ChUpZ);
  assign same   = (lo_dig && c_dig) || (lo_low && c_low) || (lo_up && c_up);

  always_comb begin
    cmd          = '0;
    cmd.last     = item_i.in_last;
    prev_char_d  = prev_char_q;
    prev_valid_d = prev_valid_q;
    dash_held_d  = dash_held_q;
    if (c == cre_pkg::ChDash) begin
      if (dash_held_q) begin
        // earlier dash goes out literally; this one stays held, or goes out too if last
        cmd.seg1_en = 1'b1;
        cmd.seg1_lo = cre_pkg::ChDash;
        cmd.seg1_hi = cre_pkg::ChDash;
        cmd.seg2_en = item_i.in_last;
        cmd.seg2_lo = cre_pkg::ChDash;
        cmd.seg2_hi = cre_pkg::ChDash;
        prev_char_d = cre_pkg::ChDash;
      end else if (prev_valid_q && !item_i.in_last) begin
        dash_held_d = 1'b1;
      end else begin
        cmd.seg1_en  = 1'b1;
        cmd.seg1_lo  = cre_pkg::ChDash;
        cmd.seg1_hi  = cre_pkg::ChDash;
        prev_char_d  = cre_pkg::ChDash;
        prev_valid_d = 1'b1;
      end
    end else begin
      if (dash_held_q) begin
        if (same && (lo <= c)) begin
          // x-x is a valid empty run
          cmd.seg1_en = (lo != c);
          cmd.seg1_lo = lo + 8'd1;
          cmd.seg1_hi = c;
        end else if (wrap_en_i && lo_low && c_up) begin
          cmd.seg1_en = (lo != cre_pkg::ChLowZ);
          cmd.seg1_lo = lo + 8'd1;
          cmd.seg1_hi = cre_pkg::ChLowZ;
          cmd.seg2_en = 1'b1;
          cmd.seg2_lo = cre_pkg::ChUpA;
          cmd.seg2_hi = c;
        end else begin
          cmd.seg1_en = 1'b1;
          cmd.seg1_lo = cre_pkg::ChDash;
          cmd.seg1_hi = cre_pkg::ChDash;
          cmd.seg2_en = 1'b1;
          cmd.seg2_lo = c;
          cmd.seg2_hi = c;
        end
        dash_held_d = 1'b0;
      end else begin
        cmd.seg1_en = 1'b1;
        cmd.seg1_lo = c;
        cmd.seg1_hi = c;
      end
      prev_char_d  = c;
      prev_valid_d = 1'b1;
    end
    if (item_i.in_last) begin
      prev_char_d  = '0;
      prev_valid_d = 1'b0;
      dash_held_d  = 1'b0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (cmd.seg1_en || cmd.seg2_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_char_q  <= '0;
      prev_valid_q <= 1'b0;
      dash_held_q  <= 1'b0;
    end else if (accept_i) begin
      prev_char_q  <= prev_char_d;
      prev_valid_q <= prev_valid_d;
      dash_held_q  <= dash_held_d;
    end
  end

  // a held dash always has a character before it
  assert property (@(posedge clk_i) disable iff (!rst_ni) dash_held_q |-> prev_valid_q)
    else $error("dash held without previous character");

endmodule

### rtl/cre_cmd_fifo.sv
// Small flop-based queue of run commands between front and back.
`timescale 1ns / 1ps
module cre_cmd_fifo #(
  parameter int unsigned Depth = cre_pkg::CmdFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cre_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cre_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cre_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("command queue overfilled");

endmodule

### rtl/cre_back.sv
// Back end: walks each run command one character per cycle into the output register while that register is free.
`timescale 1ns / 1ps
module cre_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  cre_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output cre_pkg::out_item_t item_o
);

  logic       act_q;
  logic [7:0] cur_q, end_q;
  logic       pend_q;
  logic [7:0] s2_lo_q, s2_hi_q;
  logic       last_q;
  logic       out_valid_q;
  cre_pkg::out_item_t out_q;

  logic slot_free, step, at_end, fin;

  assign slot_free = !out_valid_q || pop_i;
  assign step      = act_q && slot_free;
  assign at_end    = (cur_q == end_q);
  assign fin       = at_end && !pend_q;
  assign cmd_pop_o = !act_q && !cmd_empty_i;
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s2_lo_q <= cmd_i.seg2_lo;
      s2_hi_q <= cmd_i.seg2_hi;
      last_q  <= cmd_i.last;
    end
    if (step) begin
      out_q.out_char   <= cur_q;
      out_q.run_last   <= fin;
      out_q.string_end <= fin && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      cur_q       <= '0;
      end_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        act_q <= 1'b1;
        if (cmd_i.seg1_en) begin
          cur_q  <= cmd_i.seg1_lo;
          end_q  <= cmd_i.seg1_hi;
          pend_q <= cmd_i.seg2_en;
        end else begin
          cur_q  <= cmd_i.seg2_lo;
          end_q  <= cmd_i.seg2_hi;
          pend_q <= 1'b0;
        end
      end else if (step) begin
        if (!at_end) begin
          cur_q <= cur_q + 8'd1;
        end else if (pend_q) begin
          cur_q  <= s2_lo_q;
          end_q  <= s2_hi_q;
          pend_q <= 1'b0;
        end else begin
          act_q <= 1'b0;
        end
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) act_q |-> (cur_q <= end_q))
    else $error("run counter past its end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.string_end) |-> out_q.run_last)
    else $error("string end without run end");

endmodule

### rtl/char_range_expander_unit.sv
// Top level of the character range expander: config register, front, command queue, back.
`timescale 1ns / 1ps
// An accepted item's command passes through the command queue and the back end's run counter into the output register.
// Throughput: one input item per cycle while the command queue has room; the back end
//   emits one character per cycle while the output register is free, after loading each new
//   run command; one command expands to at most 51 characters.
// Reset (async, active low): no pending dash, no previous character, queue and output
//   register empty, wrap_enable = 1.
module char_range_expander_unit #(
  parameter int unsigned CmdFifoDepth = cre_pkg::CmdFifoDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input item queue side
  input  logic                           push,
  output logic                           full,
  input  cre_pkg::in_item_t              in_item_i,
  // result queue side
  output logic                           empty,
  input  logic                           pop,
  output cre_pkg::out_item_t             out_item_o,
  // APB-style config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cre_pkg::CfgAddrW-1:0]   paddr,
  input  logic [cre_pkg::CfgDataW-1:0]   pwdata,
  output logic [cre_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);

  // Config register: one bit at byte address 0; paddr[2] is the register index.
  logic wrap_enable_q;
  logic cfg_wr, cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == cre_pkg::CfgWrapIdx);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_hit ? {{(cre_pkg::CfgDataW-1){1'b0}}, wrap_enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_enable_q <= cre_pkg::WrapEnReset;
    end else if (cfg_wr && cfg_hit) begin
      wrap_enable_q <= pwdata[0];
    end
  end

  // Front: classification happens in the accept cycle; only items that produce
  // output push a command. Input stalls while the command queue is full.
  logic          cmd_full, cmd_empty, cmd_push, cmd_pop;
  cre_pkg::cmd_t cmd_in, cmd_out;
  logic          accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  cre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .wrap_en_i  (wrap_enable_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cre_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  // Back: expands one command at a time into the registered result slot.
  cre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule

### tb/sv/tb_char_range_expander_unit.sv
// Self-checking testbench for char_range_expander_unit: stimulus, expansion predictor, result check.
`timescale 1ns / 1ps
module tb_char_range_expander_unit;

  // Clock period and run shaping
  localparam int unsigned HalfPeriod        = 6;
  localparam int unsigned HoldCycles        = 300;  // long receiver hold-off, fills the block
  localparam int unsigned RandItemsPerPhase = 130;  // three random phases, at least 390 items in all
  localparam int unsigned SettleCycles      = 10;   // pipeline registers plus back-end run load

  // wrap_enable is register 0, byte address 0
  localparam logic [cre_pkg::CfgAddrW-1:0] WrapAddr = {cre_pkg::CfgWrapIdx, 2'b00};

  typedef enum int unsigned {ClsOther, ClsDigit, ClsLower, ClsUpper} char_cls_e;
  typedef enum int unsigned {TokRange, TokWrap, TokBad, TokPlain, TokDashes, TokRaw} token_e;
  typedef enum int unsigned {RxFree, RxCoin, RxSparse, RxRare} rx_mode_e;

  // ---------------------------------------------------------------------------
  // Expansion predictor and store of expected characters.
  // note_input() expands one accepted item into the characters it must cause;
  // check_result() compares one popped item against the oldest of them.
  // ---------------------------------------------------------------------------
  class range_scoreboard;
    bit                 wrap_on;
    logic [7:0]         last_ch;       // last character taken into the text
    bit                 have_prev;     // a previous character exists in this string
    bit                 dash_pending;  // a dash read but not yet emitted
    cre_pkg::out_item_t expected_q[$];
    int unsigned        errors;

    function new();
      wrap_on      = cre_pkg::WrapEnReset;
      last_ch      = '0;
      have_prev    = 1'b0;
      dash_pending = 1'b0;
      errors       = 0;
    endfunction

    static function char_cls_e char_class(logic [7:0] ch);
      if (ch >= cre_pkg::ChZero && ch <= cre_pkg::ChNine) return ClsDigit;
      if (ch >= cre_pkg::ChLowA && ch <= cre_pkg::ChLowZ) return ClsLower;
      if (ch >= cre_pkg::ChUpA && ch <= cre_pkg::ChUpZ) return ClsUpper;
      return ClsOther;
    endfunction

    function void push_char(logic [7:0] ch);
      cre_pkg::out_item_t r;
      r.out_char   = ch;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      expected_q.push_back(r);
    endfunction

    // inclusive run; empty when lo > hi
    function void push_run(int lo, int hi);
      for (int c = lo; c <= hi; c++) push_char(8'(c));
    endfunction

    function void note_input(cre_pkg::in_item_t it);
      int unsigned first;
      char_cls_e   lo_cls;
      char_cls_e   hi_cls;
      first = expected_q.size();
      if (it.in_char == cre_pkg::ChDash) begin
        if (dash_pending) begin
          // second dash: held one goes out literally; new one stays held, or goes out if last
          push_char(cre_pkg::ChDash);
          last_ch = cre_pkg::ChDash;
          if (it.in_last) push_char(cre_pkg::ChDash);
        end else if (have_prev && !it.in_last) begin
          dash_pending = 1'b1;
        end else begin
          // leading or trailing dash
          push_char(cre_pkg::ChDash);
          last_ch   = cre_pkg::ChDash;
          have_prev = 1'b1;
        end
      end else begin
        if (dash_pending) begin
          lo_cls = char_class(last_ch);
          hi_cls = char_class(it.in_char);
          if (lo_cls == hi_cls && lo_cls != ClsOther && last_ch <= it.in_char) begin
            // start was already emitted, so the run begins one above it
            push_run(int'(last_ch) + 1, int'(it.in_char));
          end else if (wrap_on && lo_cls == ClsLower && hi_cls == ClsUpper) begin
            push_run(int'(last_ch) + 1, int'(cre_pkg::ChLowZ));
            push_run(int'(cre_pkg::ChUpA), int'(it.in_char));
          end else begin
            push_char(cre_pkg::ChDash);
            push_char(it.in_char);
          end
          dash_pending = 1'b0;
        end else begin
          push_char(it.in_char);
        end
        last_ch   = it.in_char;
        have_prev = 1'b1;
      end
      if (expected_q.size() > first) begin
        expected_q[expected_q.size() - 1].run_last   = 1'b1;
        expected_q[expected_q.size() - 1].string_end = it.in_last;
      end
      if (it.in_last) begin
        last_ch      = '0;
        have_prev    = 1'b0;
        dash_pending = 1'b0;
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      $display("%0t ns  ERROR %s", $time, msg);
    endtask

    task check_result(cre_pkg::out_item_t got);
      cre_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("unexpected item, out_char %02h", got.out_char));
      end else begin
        want = expected_q.pop_front();
        if (got.out_char !== want.out_char)
          log_mismatch($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
        if (got.run_last !== want.run_last)
          log_mismatch($sformatf("run_last %b, want %b (out_char %02h)",
                                 got.run_last, want.run_last, want.out_char));
        if (got.string_end !== want.string_end)
          log_mismatch($sformatf("string_end %b, want %b (out_char %02h)",
                                 got.string_end, want.string_end, want.out_char));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block under test
  // ---------------------------------------------------------------------------
  logic                         clk_i;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  cre_pkg::in_item_t            in_item;
  logic                         empty;
  logic                         pop;
  cre_pkg::out_item_t           out_item;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cre_pkg::CfgAddrW-1:0] paddr;
  logic [cre_pkg::CfgDataW-1:0] pwdata;
  logic [cre_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  char_range_expander_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  range_scoreboard sb;
  int unsigned     hold_requests = 0;  // bumped by the stimulus, served by the receiver
  int unsigned     burst_left    = 0;  // items left in the sender's current burst

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Both handshakes are observed right after the rising edge, before the block's
  // registers update, so what is seen is what the block saw at that edge.
  always @(posedge clk_i) begin : handshake_watch
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(out_item);
      if (push && !full) sb.note_input(in_item);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pops on a pattern of its own that changes mode at random; on request
  // it holds off for HoldCycles so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned holds_done;
    int unsigned tick;
    rx_mode_e    mode;
    holds_done = 0;
    tick       = 0;
    mode       = RxFree;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests > holds_done) begin
        holds_done++;
        pop = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (tick == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          tick = $urandom_range(20, 120);
        end
        tick--;
        case (mode)
          RxFree:   pop = 1'b1;
          RxCoin:   pop = ($urandom_range(0, 1) == 1);
          RxSparse: pop = (tick % 4 == 0);            // three stalls in four
          default:  pop = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. All start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one item until taken, then pace: bursts of random length with random
  // gaps, some bursts long enough to run without any idling.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    bit taken;
    taken           = 1'b0;
    in_item.in_char = ch;
    in_item.in_last = lst;
    push            = 1'b1;
    while (!taken) begin
      @(posedge clk_i);
      taken = !full;
      @(negedge clk_i);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] class_char(char_cls_e k);
    case (k)
      ClsDigit: return cre_pkg::ChZero + 8'($urandom_range(0, 9));
      ClsLower: return cre_pkg::ChLowA + 8'($urandom_range(0, 25));
      ClsUpper: return cre_pkg::ChUpA + 8'($urandom_range(0, 25));
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed range text, with plain characters, dash runs and raw bytes.
  task automatic send_random_text(inout int unsigned sent);
    logic [7:0]  txt[$];
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  t;
    char_cls_e   ka;
    char_cls_e   kb;
    int unsigned r;
    token_e      tok;
    repeat ($urandom_range(1, 5)) begin
      r   = $urandom_range(0, 9);
      tok = (r < 4) ? TokRange : (r < 5) ? TokWrap : (r < 6) ? TokBad :
            (r < 8) ? TokPlain : (r < 9) ? TokDashes : TokRaw;
      case (tok)
        TokRange: begin
          ka = char_cls_e'($urandom_range(1, 3));
          a  = class_char(ka);
          b  = class_char(ka);
          if (a > b) begin
            t = a; a = b; b = t;
          end
          txt.push_back(a); txt.push_back(cre_pkg::ChDash); txt.push_back(b);
          // chain: the shared end must not repeat
          if ($urandom_range(0, 2) == 0) begin
            txt.push_back(cre_pkg::ChDash);
            txt.push_back(class_char(ka));
          end
        end
        TokWrap: begin
          txt.push_back(class_char(ClsLower));
          txt.push_back(cre_pkg::ChDash);
          txt.push_back(class_char(ClsUpper));
        end
        TokBad: begin
          ka = char_cls_e'($urandom_range(1, 3));
          kb = char_cls_e'($urandom_range(1, 3));
          a  = class_char(ka);
          b  = class_char(kb);
          if (ka == kb && a < b) begin
            t = a; a = b; b = t;
          end
          txt.push_back(a); txt.push_back(cre_pkg::ChDash); txt.push_back(b);
        end
        TokPlain: begin
          if ($urandom_range(0, 1) == 1)
            txt.push_back(class_char(char_cls_e'($urandom_range(1, 3))));
          else txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        TokDashes: begin
          repeat ($urandom_range(1, 3)) txt.push_back(cre_pkg::ChDash);
        end
        default: begin
          txt.push_back(class_char(ClsOther));
          if ($urandom_range(0, 1) == 1) begin
            txt.push_back(cre_pkg::ChDash);
            txt.push_back(class_char(ClsOther));
          end
        end
      endcase
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    sent += txt.size();
  endtask

  // Let every expected item arrive, then let the pipeline settle.
  task automatic drain();
    push = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [cre_pkg::CfgAddrW-1:0] addr,
                           input logic [cre_pkg::CfgDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [cre_pkg::CfgAddrW-1:0] addr,
                          output logic [cre_pkg::CfgDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_wrap(input bit want);
    logic [cre_pkg::CfgDataW-1:0] rd;
    apb_read(WrapAddr, rd);
    if (rd !== cre_pkg::CfgDataW'(want))
      sb.log_mismatch($sformatf("wrap_enable reads %0h, want %0h", rd, want));
  endtask

  // Only written with the block idle.
  task automatic write_wrap(input bit val);
    drain();
    apb_write(WrapAddr, cre_pkg::CfgDataW'(val));
    sb.wrap_on = val;
    check_wrap(val);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent;
    rst_ni  = 1'b0;
    push    = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sb      = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_wrap(cre_pkg::WrapEnReset);

    // Directed, wrap on (reset value)
    send_string("a-Z");    // widest run: through z, then A..Z
    send_string("-0-9");   // leading dash literal, then digit range
    send_string("e-c-g");  // descending literal, then c shared into c..g
    send_string("Z-a");    // upper to lower stays literal
    send_string("x-x");    // equal ends: empty run on the final item
    send_string("a--");    // held dash then trailing dash: both literal
    send_char(8'h00, 1'b0);  // other bytes across a dash stay literal
    send_char(cre_pkg::ChDash, 1'b0);
    send_char(8'hFF, 1'b1);

    // Directed, wrap off: lower to upper is literal
    write_wrap(1'b0);
    send_string("a-Z");

    // Random phases: wrap off, on, off. Each opens with a long receiver hold.
    for (int p = 0; p < 3; p++) begin
      if (p > 0) write_wrap(p[0]);
      hold_requests++;
      sent = 0;
      while (sent < RandItemsPerPhase) send_random_text(sent);
    end

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Worst case is ~1.5 ms (51 chars per item at the slowest pop rate); allow 10x.
  initial begin : watchdog
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
